[rtl/sps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, constants and drive tables of the stepper phase sequencer:
// full and half step pin tables and the quarter-wave sine ROM.
// ----------------------------------------------------------------------------
package sps_pkg;

    // Field widths
    localparam int PERIOD_WIDTH    = 16;
    localparam int COUNT_WIDTH     = 16;
    localparam int PHASE_WIDTH     = 8;
    localparam int LEVEL_WIDTH     = 8;
    localparam int CFG_INDEX_WIDTH = 2;

    // Microstep resolution: the ROM covers 4 << ROM_SCALER phases per turn
    localparam int MAX_SCALER = 6;
    localparam int ROM_SCALER = 6;

    // Reset value of the step period
    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = PERIOD_WIDTH'(1000);

    // Opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Configuration register indexes
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
    localparam cfg_index_t CFG_DRIVE_MODE = 2'd0;
    localparam cfg_index_t CFG_SCALER     = 2'd1;
    localparam cfg_index_t CFG_PERIOD     = 2'd2;

    // Drive modes; the unused code drives as microstep
    typedef enum logic [1:0] {
        MODE_FULL  = 2'd0,
        MODE_HALF  = 2'd1,
        MODE_MICRO = 2'd2
    } drive_mode_t;

    // Pin levels of one drive state
    typedef struct packed {
        logic [LEVEL_WIDTH-1:0] a;
        logic [LEVEL_WIDTH-1:0] not_a;
        logic [LEVEL_WIDTH-1:0] b;
        logic [LEVEL_WIDTH-1:0] not_b;
    } levels_t;

    // What the level generator needs to know about one drive state
    typedef struct packed {
        logic [1:0]             mode;
        logic [2:0]             scaler;
        logic                   reverse;
        logic [PHASE_WIDTH-1:0] phase;
    } drive_ctrl_t;

    localparam logic [LEVEL_WIDTH-1:0] LVL_H = 8'd255;
    localparam logic [LEVEL_WIDTH-1:0] LVL_L = 8'd0;

    // Full step pin table, active low
    function automatic levels_t full_levels(input logic [1:0] e);
        levels_t lv;
        case (e)
            2'd0:    lv = '{LVL_L, LVL_H, LVL_L, LVL_H};
            2'd1:    lv = '{LVL_L, LVL_H, LVL_H, LVL_L};
            2'd2:    lv = '{LVL_H, LVL_L, LVL_H, LVL_L};
            default: lv = '{LVL_H, LVL_L, LVL_L, LVL_H};
        endcase
        return lv;
    endfunction

    // Half step pin table, active low
    function automatic levels_t half_levels(input logic [2:0] e);
        levels_t lv;
        case (e)
            3'd0:    lv = '{LVL_H, LVL_H, LVL_H, LVL_L};
            3'd1:    lv = '{LVL_H, LVL_L, LVL_H, LVL_L};
            3'd2:    lv = '{LVL_H, LVL_L, LVL_H, LVL_H};
            3'd3:    lv = '{LVL_H, LVL_L, LVL_L, LVL_H};
            3'd4:    lv = '{LVL_H, LVL_H, LVL_L, LVL_H};
            3'd5:    lv = '{LVL_L, LVL_H, LVL_L, LVL_H};
            3'd6:    lv = '{LVL_L, LVL_H, LVL_H, LVL_H};
            default: lv = '{LVL_L, LVL_H, LVL_H, LVL_L};
        endcase
        return lv;
    endfunction

    // Quarter wave: truncated 255*sin(2*pi*r/256), r = 0..64
    function automatic logic [LEVEL_WIDTH-1:0] quarter_sin(input logic [6:0] r);
        logic [LEVEL_WIDTH-1:0] v;
        case (r)
            7'd0:  v = 8'd0;   7'd1:  v = 8'd6;   7'd2:  v = 8'd12;  7'd3:  v = 8'd18;
            7'd4:  v = 8'd24;  7'd5:  v = 8'd31;  7'd6:  v = 8'd37;  7'd7:  v = 8'd43;
            7'd8:  v = 8'd49;  7'd9:  v = 8'd55;  7'd10: v = 8'd61;  7'd11: v = 8'd68;
            7'd12: v = 8'd74;  7'd13: v = 8'd79;  7'd14: v = 8'd85;  7'd15: v = 8'd91;
            7'd16: v = 8'd97;  7'd17: v = 8'd103; 7'd18: v = 8'd109; 7'd19: v = 8'd114;
            7'd20: v = 8'd120; 7'd21: v = 8'd125; 7'd22: v = 8'd131; 7'd23: v = 8'd136;
            7'd24: v = 8'd141; 7'd25: v = 8'd146; 7'd26: v = 8'd151; 7'd27: v = 8'd156;
            7'd28: v = 8'd161; 7'd29: v = 8'd166; 7'd30: v = 8'd171; 7'd31: v = 8'd175;
            7'd32: v = 8'd180; 7'd33: v = 8'd184; 7'd34: v = 8'd188; 7'd35: v = 8'd193;
            7'd36: v = 8'd197; 7'd37: v = 8'd201; 7'd38: v = 8'd204; 7'd39: v = 8'd208;
            7'd40: v = 8'd212; 7'd41: v = 8'd215; 7'd42: v = 8'd218; 7'd43: v = 8'd221;
            7'd44: v = 8'd224; 7'd45: v = 8'd227; 7'd46: v = 8'd230; 7'd47: v = 8'd233;
            7'd48: v = 8'd235; 7'd49: v = 8'd237; 7'd50: v = 8'd240; 7'd51: v = 8'd242;
            7'd52: v = 8'd244; 7'd53: v = 8'd245; 7'd54: v = 8'd247; 7'd55: v = 8'd248;
            7'd56: v = 8'd250; 7'd57: v = 8'd251; 7'd58: v = 8'd252; 7'd59: v = 8'd253;
            7'd60: v = 8'd253; 7'd61: v = 8'd254; 7'd62: v = 8'd254; 7'd63: v = 8'd254;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

endpackage

[rtl/sps_level_gen.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_level_gen
// Pin levels of one drive state: full and half step table lookup, or sine
// microstep with the cosine on coil A and the sine on coil B (swapped on
// reverse), split by sign into high and low side and driven active low.
// ----------------------------------------------------------------------------
module sps_level_gen (
    input  sps_pkg::drive_ctrl_t ctrl,
    output sps_pkg::levels_t     levels
);
    import sps_pkg::*;

    logic [1:0]             full_entry;
    logic [2:0]             half_entry;
    logic [2:0]             scaler_sat;
    logic [2:0]             phase_shift;
    logic [PHASE_WIDTH-1:0] rom_phase;
    logic [PHASE_WIDTH-1:0] cos_phase;
    logic [LEVEL_WIDTH-1:0] cos_mag;
    logic [LEVEL_WIDTH-1:0] sin_mag;
    logic [LEVEL_WIDTH-1:0] cos_hi;
    logic [LEVEL_WIDTH-1:0] cos_lo;
    logic [LEVEL_WIDTH-1:0] sin_hi;
    logic [LEVEL_WIDTH-1:0] sin_lo;
    levels_t                micro_levels;

    // Forward moves walk the tables backwards
    assign full_entry = ctrl.reverse ? ctrl.phase[1:0] : ~ctrl.phase[1:0];
    assign half_entry = ctrl.reverse ? ctrl.phase[2:0] : ~ctrl.phase[2:0];

    // Saturate the scaler and spread the phase over the full ROM turn
    assign scaler_sat  = (ctrl.scaler > 3'(MAX_SCALER)) ? 3'(MAX_SCALER) : ctrl.scaler;
    assign phase_shift = 3'(ROM_SCALER) - scaler_sat;
    assign rom_phase   = ctrl.phase << phase_shift;
    assign cos_phase   = rom_phase + 8'd64;

    // Mirror odd quadrants in the quarter-wave ROM
    assign cos_mag = cos_phase[6] ? quarter_sin(7'd64 - {1'b0, cos_phase[5:0]})
                                  : quarter_sin({1'b0, cos_phase[5:0]});
    assign sin_mag = rom_phase[6] ? quarter_sin(7'd64 - {1'b0, rom_phase[5:0]})
                                  : quarter_sin({1'b0, rom_phase[5:0]});

    // Split by sign: upper half-turn goes to the low side
    assign cos_hi = cos_phase[7] ? LVL_L : cos_mag;
    assign cos_lo = cos_phase[7] ? cos_mag : LVL_L;
    assign sin_hi = rom_phase[7] ? LVL_L : sin_mag;
    assign sin_lo = rom_phase[7] ? sin_mag : LVL_L;

    // Invert for active low drive, swap coils on reverse
    always_comb
    begin
        if (ctrl.reverse)
        begin
            micro_levels = '{~sin_hi, ~sin_lo, ~cos_hi, ~cos_lo};
        end
        else
        begin
            micro_levels = '{~cos_hi, ~cos_lo, ~sin_hi, ~sin_lo};
        end
    end

    // Select by drive mode
    always_comb
    begin
        case (ctrl.mode)
            MODE_FULL: levels = full_levels(full_entry);
            MODE_HALF: levels = half_levels(half_entry);
            default:   levels = micro_levels;
        endcase
    end

endmodule

[rtl/stepper_phase_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_phase_sequencer
// Full step, half step and sine microstep phase sequencer for a two-coil
// stepper motor, driven by start and tick transactions.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle. A start transaction
// launches a move and its first drive state is registered into the result
// buffer at acceptance; each tick transaction that completes a step period
// does the same with the next state. All of the work for a transaction is
// done in the cycle of acceptance, between the move state registers and a
// two-entry result buffer, so the input stays ready while one result waits
// downstream and stalls only when both entries are full. Configuration
// writes are taken in any cycle (cfg_ready is high).
module stepper_phase_sequencer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Item input
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  opcode,
    input  logic signed [sps_pkg::COUNT_WIDTH-1:0] move_steps,
    // Result output
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [sps_pkg::LEVEL_WIDTH-1:0]       level_a,
    output logic [sps_pkg::LEVEL_WIDTH-1:0]       level_not_a,
    output logic [sps_pkg::LEVEL_WIDTH-1:0]       level_b,
    output logic [sps_pkg::LEVEL_WIDTH-1:0]       level_not_b,
    output logic                                  last_state,
    // Configuration write
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  sps_pkg::cfg_index_t                   cfg_index,
    input  logic [sps_pkg::PERIOD_WIDTH-1:0]      cfg_data
);
    import sps_pkg::*;

    // Configuration registers
    logic [1:0]              drive_mode_reg;
    logic [2:0]              scaler_reg;
    logic [PERIOD_WIDTH-1:0] step_period_reg;

    // Move state
    logic                    busy_reg,        busy_next;
    logic                    reverse_reg,     reverse_next;
    logic [PHASE_WIDTH-1:0]  phase_index_reg, phase_index_next;
    logic [COUNT_WIDTH-1:0]  states_left_reg, states_left_next;
    logic [PERIOD_WIDTH-1:0] tick_count_reg,  tick_count_next;

    // Result buffer
    logic                    out_valid_reg;
    levels_t                 out_levels_reg;
    logic                    out_last_reg;
    logic                    skid_valid_reg;
    levels_t                 skid_levels_reg;
    logic                    skid_last_reg;

    logic                    in_accept;
    logic                    emit;
    logic                    emit_last;
    drive_ctrl_t             emit_ctrl;
    levels_t                 emit_levels;
    logic [COUNT_WIDTH-1:0]  steps_raw;
    logic [COUNT_WIDTH-1:0]  start_mag;
    logic [PERIOD_WIDTH-1:0] period_eff;
    logic [PERIOD_WIDTH-1:0] tick_inc;
    logic [COUNT_WIDTH-1:0]  states_dec;

    assign in_ready  = ~skid_valid_reg;
    assign in_accept = in_valid & in_ready;
    assign cfg_ready = 1'b1;

    // Hold configuration; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_mode_reg  <= MODE_FULL;
            scaler_reg      <= '0;
            step_period_reg <= PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DRIVE_MODE: drive_mode_reg  <= cfg_data[1:0];
                CFG_SCALER:     scaler_reg      <= cfg_data[2:0];
                CFG_PERIOD:     step_period_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Magnitude of the count; the most negative count maps onto itself
    assign steps_raw  = move_steps;
    assign start_mag  = steps_raw[COUNT_WIDTH-1] ? (~steps_raw + 1'b1) : steps_raw;
    assign period_eff = (step_period_reg == '0) ? PERIOD_WIDTH'(1) : step_period_reg;
    assign tick_inc   = tick_count_reg + 1'b1;
    assign states_dec = states_left_reg - 1'b1;

    // Advance the move on start and tick transactions
    always_comb
    begin
        busy_next        = busy_reg;
        reverse_next     = reverse_reg;
        phase_index_next = phase_index_reg;
        states_left_next = states_left_reg;
        tick_count_next  = tick_count_reg;
        emit             = 1'b0;
        emit_last        = 1'b0;
        emit_ctrl.mode    = drive_mode_reg;
        emit_ctrl.scaler  = scaler_reg;
        emit_ctrl.reverse = reverse_reg;
        emit_ctrl.phase   = phase_index_reg;
        if (in_accept)
        begin
            if (opcode == OP_START)
            begin
                if (!busy_reg && steps_raw != '0)
                begin
                    reverse_next      = steps_raw[COUNT_WIDTH-1];
                    states_left_next  = start_mag;
                    tick_count_next   = '0;
                    busy_next         = 1'b1;
                    phase_index_next  = PHASE_WIDTH'(1);
                    emit              = 1'b1;
                    emit_ctrl.reverse = steps_raw[COUNT_WIDTH-1];
                    emit_ctrl.phase   = '0;
                end
            end
            else if (busy_reg)
            begin
                if (tick_inc != '0 && tick_inc < period_eff)
                begin
                    tick_count_next = tick_inc;
                end
                else
                begin
                    tick_count_next  = '0;
                    states_left_next = states_dec;
                    busy_next        = (states_dec != '0);
                    phase_index_next = phase_index_reg + 1'b1;
                    emit             = 1'b1;
                    emit_last        = (states_dec == '0);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            reverse_reg     <= 1'b0;
            phase_index_reg <= '0;
            states_left_reg <= '0;
            tick_count_reg  <= '0;
        end
        else
        begin
            busy_reg        <= busy_next;
            reverse_reg     <= reverse_next;
            phase_index_reg <= phase_index_next;
            states_left_reg <= states_left_next;
            tick_count_reg  <= tick_count_next;
        end
    end

    sps_level_gen u_level_gen (
        .ctrl   (emit_ctrl),
        .levels (emit_levels)
    );

    // Result buffer: output register plus one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg  <= skid_valid_reg | emit;
            skid_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_levels_reg <= skid_levels_reg;
                out_last_reg   <= skid_last_reg;
            end
            else
            begin
                out_levels_reg <= emit_levels;
                out_last_reg   <= emit_last;
            end
        end
        else if (emit)
        begin
            skid_levels_reg <= emit_levels;
            skid_last_reg   <= emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign level_a     = out_levels_reg.a;
    assign level_not_a = out_levels_reg.not_a;
    assign level_b     = out_levels_reg.b;
    assign level_not_b = out_levels_reg.not_b;
    assign last_state  = out_last_reg;

`ifndef NO_ASSERTIONS
    // The skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // A running move always has states to come
    a_busy_has_states: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (states_left_reg != '0))
        else $error("busy with no states left");

    // The final state ends the move
    a_last_ends_move: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_last) |=> !busy_reg)
        else $error("move still busy after final state");

    // Nothing is emitted while idle unless a start arrives
    a_idle_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !busy_reg) |-> (opcode == OP_START))
        else $error("state emitted while idle without a start");
`endif

endmodule

[bench/sps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_checker
// Watches the item, result and configuration channels of the stepper phase
// sequencer, keeps its own copy of the move state and registers, works out
// the drive state that each accepted transaction should produce and compares
// every result transaction with the oldest state still awaited.
// ----------------------------------------------------------------------------
module sps_checker
    import sps_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          opcode,
    input  logic signed [COUNT_WIDTH-1:0] move_steps,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [LEVEL_WIDTH-1:0]        level_a,
    input  logic [LEVEL_WIDTH-1:0]        level_not_a,
    input  logic [LEVEL_WIDTH-1:0]        level_b,
    input  logic [LEVEL_WIDTH-1:0]        level_not_b,
    input  logic                          last_state,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  cfg_index_t                    cfg_index,
    input  logic [PERIOD_WIDTH-1:0]       cfg_data,
    output int                            errors,
    output int                            outstanding,
    output logic                          moving
);

    typedef struct packed {
        levels_t lv;
        logic    last;
    } drive_state_t;

    // Pin tables, active low: {a, not_a, b, not_b}
    levels_t full_table [4] = '{32'h00FF00FF, 32'h00FFFF00, 32'hFF00FF00, 32'hFF0000FF};
    levels_t half_table [8] = '{32'hFFFFFF00, 32'hFF00FF00, 32'hFF00FFFF, 32'hFF0000FF,
                                32'hFFFF00FF, 32'h00FF00FF, 32'h00FFFFFF, 32'h00FFFF00};

    // First quarter of 255*sin over 256 phases, truncated
    logic [LEVEL_WIDTH-1:0] sine_quarter [65] = '{
        0, 6, 12, 18, 24, 31, 37, 43, 49, 55, 61, 68, 74, 79, 85, 91,
        97, 103, 109, 114, 120, 125, 131, 136, 141, 146, 151, 156, 161, 166, 171, 175,
        180, 184, 188, 193, 197, 201, 204, 208, 212, 215, 218, 221, 224, 227, 230, 233,
        235, 237, 240, 242, 244, 245, 247, 248, 250, 251, 252, 253, 253, 254, 254, 254,
        255
    };

    // Register copies
    logic [1:0]              mode_reg;
    logic [2:0]              scaler_reg;
    logic [PERIOD_WIDTH-1:0] period_reg;

    // Move state
    logic                    reverse_dir;
    logic [PHASE_WIDTH-1:0]  phase_cnt;
    logic [COUNT_WIDTH-1:0]  states_left;
    logic [PERIOD_WIDTH-1:0] tick_cnt;

    drive_state_t            awaited_states [$];
    drive_state_t            oldest;

    // Signed sine over 256 phases, built from the quarter wave
    function automatic int signed_sine(input logic [PHASE_WIDTH-1:0] p);
        int v;
        v = p[6] ? int'(sine_quarter[64 - int'(p[5:0])]) : int'(sine_quarter[p[5:0]]);
        return p[7] ? -v : v;
    endfunction

    // Pin levels of one drive state
    function automatic levels_t coil_levels(input logic [1:0] mode, input logic [2:0] scaler,
                                            input logic rev, input logic [PHASE_WIDTH-1:0] idx);
        levels_t                lv;
        logic [PHASE_WIDTH-1:0] p;
        int                     sc;
        int                     cos_v;
        int                     sin_v;
        int                     swap;
        if (mode == MODE_FULL)
        begin
            lv = full_table[rev ? idx[1:0] : 2'd3 - idx[1:0]];
        end
        else if (mode == MODE_HALF)
        begin
            lv = half_table[rev ? idx[2:0] : 3'd7 - idx[2:0]];
        end
        else
        begin
            // Saturate the scaler, then spread the phase over the full ROM turn
            sc = int'(scaler);
            if (sc > MAX_SCALER)
                sc = MAX_SCALER;
            if (sc > ROM_SCALER)
                sc = ROM_SCALER;
            p = PHASE_WIDTH'((int'(idx) & ((4 << sc) - 1)) << (ROM_SCALER - sc));
            cos_v = signed_sine(PHASE_WIDTH'(int'(p) + 64));
            sin_v = signed_sine(p);
            // Reverse moves swap the coil pairs
            if (rev)
            begin
                swap  = cos_v;
                cos_v = sin_v;
                sin_v = swap;
            end
            lv.a     = LVL_H - LEVEL_WIDTH'(cos_v > 0 ? cos_v : 0);
            lv.not_a = LVL_H - LEVEL_WIDTH'(cos_v < 0 ? -cos_v : 0);
            lv.b     = LVL_H - LEVEL_WIDTH'(sin_v > 0 ? sin_v : 0);
            lv.not_b = LVL_H - LEVEL_WIDTH'(sin_v < 0 ? -sin_v : 0);
        end
        return lv;
    endfunction

    // Queue the next drive state of the move and advance the phase
    task automatic produce_state(input logic last);
        drive_state_t st;
        st.lv   = coil_levels(mode_reg, scaler_reg, reverse_dir, phase_cnt);
        st.last = last;
        awaited_states.push_back(st);
        phase_cnt = phase_cnt + 1'b1;
    endtask

    // Apply one accepted item transaction to the move state
    task automatic take_item(input logic op, input logic signed [COUNT_WIDTH-1:0] steps);
        logic [PERIOD_WIDTH-1:0] span;
        if (op == OP_START)
        begin
            // Zero counts and starts during a move are dropped
            if (!moving && steps != 0)
            begin
                reverse_dir = steps < 0;
                states_left = reverse_dir ? COUNT_WIDTH'(-steps) : COUNT_WIDTH'(steps);
                phase_cnt   = '0;
                tick_cnt    = '0;
                moving      = 1'b1;
                produce_state(1'b0);
            end
        end
        else if (moving)
        begin
            span     = (period_reg == '0) ? PERIOD_WIDTH'(1) : period_reg;
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt == '0 || tick_cnt >= span)
            begin
                tick_cnt    = '0;
                states_left = states_left - 1'b1;
                moving      = (states_left != '0);
                produce_state(states_left == '0);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [LEVEL_WIDTH-1:0] want, got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Compare results first: a result never leaves in the cycle of its item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    = MODE_FULL;
            scaler_reg  = '0;
            period_reg  = PERIOD_RESET;
            reverse_dir = 1'b0;
            phase_cnt   = '0;
            states_left = '0;
            tick_cnt    = '0;
            moving      = 1'b0;
            errors      = 0;
            awaited_states.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_states.size() == 0)
                begin
                    errors++;
                    $display("%0t: result expected none, got a=%0d na=%0d b=%0d nb=%0d last=%0d",
                             $time, level_a, level_not_a, level_b, level_not_b, last_state);
                end
                else
                begin
                    oldest = awaited_states.pop_front();
                    check_field("level_a", oldest.lv.a, level_a);
                    check_field("level_not_a", oldest.lv.not_a, level_not_a);
                    check_field("level_b", oldest.lv.b, level_b);
                    check_field("level_not_b", oldest.lv.not_b, level_not_b);
                    check_field("last_state", LEVEL_WIDTH'(oldest.last), LEVEL_WIDTH'(last_state));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DRIVE_MODE: mode_reg   = cfg_data[1:0];
                    CFG_SCALER:     scaler_reg = cfg_data[2:0];
                    CFG_PERIOD:     period_reg = cfg_data;
                    default:        ;
                endcase
            end
            if (in_valid && in_ready)
                take_item(opcode, move_steps);
        end
        outstanding = awaited_states.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the stepper phase sequencer: directed moves over
// every drive mode and corner of the registers, then random move sequences
// under a sweep of settings, with random idling on both channels, a long
// result hold-off and a pause for the pipeline to drain between settings.
// ----------------------------------------------------------------------------
module tb;
    import sps_pkg::*;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 80;
    localparam logic [1:0]  MODE_SPARE    = 2'd3;
    localparam cfg_index_t  CFG_SPARE     = 2'd3;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic                          opcode;
    logic signed [COUNT_WIDTH-1:0] move_steps;
    logic                          out_valid;
    logic                          out_ready;
    logic [LEVEL_WIDTH-1:0]        level_a;
    logic [LEVEL_WIDTH-1:0]        level_not_a;
    logic [LEVEL_WIDTH-1:0]        level_b;
    logic [LEVEL_WIDTH-1:0]        level_not_b;
    logic                          last_state;
    logic                          cfg_valid;
    logic                          cfg_ready;
    cfg_index_t                    cfg_index;
    logic [PERIOD_WIDTH-1:0]       cfg_data;

    int                            errors;
    int                            outstanding;
    logic                          moving;
    int                            cycle_count;
    logic                          tx_steady;
    logic                          rx_steady;
    logic                          hold_req;
    logic                          hold_taken;

    stepper_phase_sequencer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .move_steps  (move_steps),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .level_a     (level_a),
        .level_not_a (level_not_a),
        .level_b     (level_b),
        .level_not_b (level_not_b),
        .last_state  (last_state),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    sps_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .move_steps  (move_steps),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .level_a     (level_a),
        .level_not_a (level_not_a),
        .level_b     (level_b),
        .level_not_b (level_not_b),
        .last_state  (last_state),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding),
        .moving      (moving)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("stepper_phase_sequencer: mismatch");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        out_ready  = 1'b0;
        hold_taken = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_taken = 1'b1;
            end
            else if (rx_steady)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 22);
        end
    end

    // Offer one item transaction; valid stays high on return
    task automatic send_item(input logic op, input logic signed [COUNT_WIDTH-1:0] steps);
        while (!tx_steady && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        move_steps <= steps;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [PERIOD_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid and wait for every awaited result, then let the block settle
    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input logic [1:0] mode, input logic [2:0] scaler,
                             input logic [PERIOD_WIDTH-1:0] period);
        settle();
        write_reg(CFG_DRIVE_MODE, {14'($urandom), mode});
        write_reg(CFG_SCALER, {13'($urandom), scaler});
        write_reg(CFG_PERIOD, period);
    endtask

    // Well-formed moves driven to completion by ticks, with some noise mixed in
    task automatic run_moves(input int count, input int max_mag);
        int mag;
        repeat (count)
        begin
            if (!moving)
            begin
                mag = $urandom_range(max_mag, 1);
                if ($urandom_range(99) < 10)
                begin
                    // Zero-count starts and idle ticks leave the block idle
                    if ($urandom_range(1) == 1)
                        send_item(OP_START, COUNT_WIDTH'(0));
                    else
                        send_item(OP_TICK, COUNT_WIDTH'($urandom));
                end
                else
                    send_item(OP_START, $urandom_range(1) == 1 ? COUNT_WIDTH'(mag)
                                                               : COUNT_WIDTH'(-mag));
            end
            else if ($urandom_range(99) < 12)
                send_item($urandom_range(1) == 1 ? OP_START : OP_TICK, COUNT_WIDTH'($urandom));
            else
                send_item(OP_TICK, COUNT_WIDTH'($urandom));
        end
    endtask

    initial
    begin
        int scaler;
        int period;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = OP_TICK;
        move_steps = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_DRIVE_MODE;
        cfg_data   = '0;
        tx_steady  = 1'b0;
        rx_steady  = 1'b0;
        hold_req   = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: tick while idle, zero count, then a full-step move and a start during it
        send_item(OP_TICK, 16'sh7FFF);
        send_item(OP_START, '0);
        send_item(OP_START, COUNT_WIDTH'(3));
        send_item(OP_START, COUNT_WIDTH'(-5));
        repeat (3) send_item(OP_TICK, '0);

        // Longest period mid-move, then zero period which steps on every tick
        configure(MODE_FULL, 3'd0, '1);
        repeat (2) send_item(OP_TICK, '1);
        configure(MODE_FULL, 3'd0, '0);
        repeat (3) send_item(OP_TICK, '0);

        // Half step in reverse
        configure(MODE_HALF, 3'd0, 16'd1);
        send_item(OP_START, COUNT_WIDTH'(-2));
        repeat (2) send_item(OP_TICK, '0);

        // Microstep with the scaler beyond its limit
        configure(MODE_MICRO, 3'd7, 16'd1);
        send_item(OP_START, COUNT_WIDTH'(4));
        repeat (4) send_item(OP_TICK, '0);

        // Unused mode drives as microstep; unused register index is ignored
        configure(MODE_SPARE, 3'd0, 16'd2);
        send_item(OP_START, COUNT_WIDTH'(-3));
        repeat (6) send_item(OP_TICK, '0);
        settle();
        write_reg(CFG_SPARE, '1);

        // Sweep of settings with random move sequences
        for (int ph = 0; ph < 12; ph++)
        begin
            tx_steady = (ph == 5);
            rx_steady = (ph == 5);
            scaler    = (ph == 2) ? 0 : (ph == 6) ? MAX_SCALER : $urandom_range(7);
            period    = (ph % 3 == 0) ? 1 : (ph == 10) ? 9 : $urandom_range(5);
            configure(2'(ph % 4), 3'(scaler), PERIOD_WIDTH'(period));
            run_moves(40, (ph == 10) ? 4 : 12);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // Long microstep move past the phase wrap; hold results off meanwhile
        configure(MODE_MICRO, 3'(MAX_SCALER), 16'd1);
        while (moving)
            send_item(OP_TICK, COUNT_WIDTH'($urandom));
        send_item(OP_START, $urandom_range(1) == 1 ? COUNT_WIDTH'(270) : COUNT_WIDTH'(-270));
        hold_req = 1'b1;
        while (moving)
            send_item(OP_TICK, COUNT_WIDTH'($urandom));
        hold_req = 1'b0;

        // Count extremes: a full-length reverse move left running
        configure(MODE_HALF, 3'd3, 16'd1);
        send_item(OP_START, COUNT_WIDTH'(-32768));
        repeat (3) send_item(OP_TICK, COUNT_WIDTH'($urandom));
        send_item(OP_START, COUNT_WIDTH'(32767));
        repeat (2) send_item(OP_TICK, COUNT_WIDTH'($urandom));

        settle();
        if (errors == 0 && outstanding == 0)
            $display("stepper_phase_sequencer: match");
        else
            $display("stepper_phase_sequencer: mismatch");
        $finish;
    end

endmodule
